// ===== rtl/mfb_pkg.sv =====
// Shared types and constants for the mono framebuffer drawing engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mfb_pkg;
  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 128;
  localparam int PAGE_ROWS        = 8;
  localparam int COORD_W          = 8;
  localparam int IDX_W            = 11;

  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_LINE  = 3'd1,
    OP_HSPAN = 3'd2,
    OP_VSPAN = 3'd3,
    OP_RECT  = 3'd4,
    OP_FILL  = 3'd5,
    OP_CLEAR = 3'd6,
    OP_READ  = 3'd7
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch command fields
    logic seg_init;   // set up current segment (seg code below)
    logic [2:0] seg;  // segment code, see SEG_* below
    logic step;       // advance one pixel
    logic rd;         // issue store read at current pixel address
    logic wr;         // write modified byte
    logic clr_init;   // reset clear address
    logic clr_wr;     // write zero at clear address
    logic row_next;   // fill: advance row
    logic rdaddr;     // read at byte_index
    logic cap;        // capture read data for result
  } mfb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic seg_done;   // current segment has no pixel left
    logic clr_last;   // clear address at last byte
    logic rows_done;  // fill has no row left
  } mfb_sts_t;

  localparam logic [2:0] SEG_HTOP = 3'd0;
  localparam logic [2:0] SEG_HBOT = 3'd1;
  localparam logic [2:0] SEG_VL   = 3'd2;
  localparam logic [2:0] SEG_VR   = 3'd3;
  localparam logic [2:0] SEG_LINE = 3'd4;
  localparam logic [2:0] SEG_ROW  = 3'd5;
  // fill: row count check pending, never used for segment set-up
  localparam logic [2:0] SEG_RCHK = 3'd6;
endpackage
`default_nettype wire

// ===== rtl/mfb_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/mfb_datapath.sv =====
// Datapath: command registers, pixel walker, Bresenham error, frame store.
// Depends on mfb_pkg and mfb_ram.
`timescale 1ns / 1ps
`default_nettype none
module mfb_datapath
  import mfb_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  wire logic         clk,
  input  wire mfb_cmd_t     cmd,
  output mfb_sts_t          sts,
  input  wire logic [7:0]   in_start_x,
  input  wire logic [7:0]   in_start_y,
  input  wire logic [7:0]   in_end_x,
  input  wire logic [7:0]   in_end_y,
  input  wire logic [7:0]   in_span_width,
  input  wire logic [7:0]   in_span_height,
  input  wire logic         in_ink,
  input  wire logic [10:0]  in_byte_index,
  output logic [7:0]        out_read_data
);
  localparam int PAGES  = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int BYTES  = PANEL_WIDTH * PAGES;
  localparam int AW     = $clog2(BYTES);
  localparam int PGW    = (PAGES > 1) ? $clog2(PAGES) : 1;

  logic [7:0] sx_r, sy_r, ex_r, ey_r, w_r, h_r;
  logic       ink_r;
  logic [10:0] idx_r;
  logic [7:0] x_r, x_nxt, y_r, y_nxt, cnt_r, cnt_nxt, row_r, row_nxt;
  logic       hz_r, hz_nxt;       // walking horizontally
  logic       line_r, line_nxt;
  logic signed [9:0] err_r, err_nxt, dx_r, dy_r;
  logic       xup_r, yup_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] paddr_r;
  logic       pvalid_r;
  logic [2:0] pbit_r;
  logic [7:0] out_r;

  // ---- pixel address (one pipeline register before the store) ----
  logic [PGW-1:0] page;
  logic       in_panel;
  logic [AW-1:0] paddr;
  assign in_panel = ({1'b0, x_r} < 9'(PANEL_WIDTH)) && ({1'b0, y_r} < 9'(PANEL_HEIGHT));
  assign page     = PGW'(y_r >> 3);
  assign paddr    = AW'(x_r) + AW'(AW'(page) * AW'(PANEL_WIDTH));

  // ---- store ----
  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata;
  logic [7:0]    mask;
  assign mask = 8'(1) << pbit_r;
  always_comb begin
    we = 1'b0; wdata = 8'h00; addr = paddr_r;
    if (cmd.clr_wr) begin
      we = 1'b1; addr = clr_r;
    end else if (cmd.wr) begin
      we = pvalid_r;
      wdata = ink_r ? (rdata | mask) : (rdata & ~mask);
    end else if (cmd.rdaddr) begin
      addr = AW'(idx_r);
    end
  end
  mfb_ram #(.WIDTH(8), .DEPTH(BYTES)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // ---- walker ----
  logic signed [10:0] e2;
  assign e2 = {err_r, 1'b0};
  always_comb begin
    x_nxt = x_r; y_nxt = y_r; cnt_nxt = cnt_r; hz_nxt = hz_r; line_nxt = line_r;
    err_nxt = err_r; row_nxt = row_r; clr_nxt = clr_r;
    if (cmd.clr_init) clr_nxt = '0;
    else if (cmd.clr_wr) clr_nxt = clr_r + AW'(1);
    if (cmd.load) row_nxt = 8'd0;
    else if (cmd.row_next) row_nxt = row_r + 8'd1;
    if (cmd.seg_init) begin
      line_nxt = 1'b0;
      unique case (cmd.seg)
        SEG_HTOP: begin x_nxt = sx_r; y_nxt = sy_r; cnt_nxt = w_r; hz_nxt = 1'b1; end
        SEG_HBOT: begin x_nxt = sx_r; y_nxt = sy_r + h_r - 8'd1; cnt_nxt = w_r; hz_nxt = 1'b1; end
        SEG_VL:   begin x_nxt = sx_r; y_nxt = sy_r; cnt_nxt = h_r; hz_nxt = 1'b0; end
        SEG_VR:   begin x_nxt = sx_r + w_r - 8'd1; y_nxt = sy_r; cnt_nxt = h_r; hz_nxt = 1'b0; end
        SEG_ROW:  begin x_nxt = sx_r; y_nxt = sy_r + row_r; cnt_nxt = w_r; hz_nxt = 1'b1; end
        default:  begin
          x_nxt = sx_r; y_nxt = sy_r; cnt_nxt = 8'd1; hz_nxt = 1'b1; line_nxt = 1'b1;
          err_nxt = dx_r - dy_r;
        end
      endcase
    end else if (cmd.step) begin
      if (line_r) begin
        if (x_r == ex_r && y_r == ey_r) cnt_nxt = 8'd0;
        else begin
          err_nxt = err_r;
          if (e2 > -11'(dy_r)) begin
            err_nxt = err_nxt - dy_r;
            x_nxt = xup_r ? x_r + 8'd1 : x_r - 8'd1;
          end
          if (e2 < 11'(dx_r)) begin
            err_nxt = err_nxt + dx_r;
            y_nxt = yup_r ? y_r + 8'd1 : y_r - 8'd1;
          end
        end
      end else begin
        cnt_nxt = cnt_r - 8'd1;
        if (hz_r) x_nxt = x_r + 8'd1;
        else y_nxt = y_r + 8'd1;
      end
    end
  end

  assign sts.seg_done  = (cnt_r == 8'd0);
  assign sts.clr_last  = (clr_r == AW'(BYTES - 1));
  assign sts.rows_done = (row_r == h_r);
  assign out_read_data = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r <= in_start_x; sy_r <= in_start_y; ex_r <= in_end_x; ey_r <= in_end_y;
      w_r <= in_span_width; h_r <= in_span_height; ink_r <= in_ink; idx_r <= in_byte_index;
      dx_r <= (in_end_x > in_start_x) ? 10'(in_end_x - in_start_x)
                                     : 10'(in_start_x - in_end_x);
      dy_r <= (in_end_y > in_start_y) ? 10'(in_end_y - in_start_y)
                                     : 10'(in_start_y - in_end_y);
      xup_r <= in_start_x < in_end_x;
      yup_r <= in_start_y < in_end_y;
    end
    x_r <= x_nxt; y_r <= y_nxt; cnt_r <= cnt_nxt; hz_r <= hz_nxt; line_r <= line_nxt;
    err_r <= err_nxt; row_r <= row_nxt; clr_r <= clr_nxt;
    if (cmd.rd) begin
      paddr_r <= paddr; pvalid_r <= in_panel; pbit_r <= y_r[2:0];
    end
    if (cmd.cap) out_r <= ({21'd0, idx_r} < 32'(BYTES)) ? rdata : 8'h00;
    else if (cmd.load) out_r <= 8'h00;
  end
endmodule
`default_nettype wire

// ===== rtl/mfb_ctrl.sv =====
// Controller state machine: sequences segments and store accesses per command.
// Depends on mfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfb_ctrl
  import mfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [2:0] in_op,
  input  wire mfb_sts_t   sts,
  output mfb_cmd_t        cmd,
  output logic            busy,
  output logic            done
);
  typedef enum logic [3:0] {
    S_IDLE, S_SEG, S_CHK, S_RD, S_WAIT, S_WR, S_NEXT, S_CLR, S_RDB, S_RDW, S_CAP, S_DONE,
    S_BINIT, S_BOOT
  } state_t;

  state_t state_r;
  op_t    op_r;
  logic [2:0] seg_r;
  logic   done_r;

  assign busy = (state_r != S_IDLE);
  assign done = done_r;

  always_comb begin
    cmd = '0;
    cmd.seg = seg_r;
    unique case (state_r)
      S_IDLE: cmd.load = start;
      S_SEG:  cmd.seg_init = 1'b1;
      S_RD:   cmd.rd = 1'b1;
      S_WR:   cmd.wr = 1'b1;
      S_NEXT: begin
        cmd.step = 1'b1;
        cmd.row_next = 1'b0;
      end
      S_CLR, S_BOOT: cmd.clr_wr = 1'b1;
      S_BINIT: cmd.clr_init = 1'b1;
      S_RDB, S_RDW: cmd.rdaddr = 1'b1;
      S_CAP:  cmd.cap = 1'b1;
      default: ;
    endcase
    if (state_r == S_IDLE && start) cmd.clr_init = 1'b1;
    if (state_r == S_CHK && sts.seg_done && op_r == OP_FILL && seg_r == SEG_ROW)
      cmd.row_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BINIT; op_r <= OP_PIXEL; seg_r <= SEG_LINE; done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          op_r <= op_t'(in_op);
          unique case (op_t'(in_op))
            OP_PIXEL, OP_LINE: begin seg_r <= SEG_LINE; state_r <= S_SEG; end
            OP_HSPAN, OP_RECT: begin seg_r <= SEG_HTOP; state_r <= S_SEG; end
            OP_VSPAN: begin seg_r <= SEG_VL; state_r <= S_SEG; end
            OP_FILL:  begin seg_r <= SEG_RCHK; state_r <= S_CHK; end
            OP_CLEAR: state_r <= S_CLR;
            default:  state_r <= S_RDB;
          endcase
        end
        S_SEG: state_r <= S_CHK;
        S_CHK: begin
          // fill alternates between a row count check and walking that row
          if (op_r == OP_FILL && seg_r == SEG_RCHK) begin
            if (sts.rows_done) state_r <= S_DONE;
            else begin seg_r <= SEG_ROW; state_r <= S_SEG; end
          end else if (sts.seg_done) begin
            if (op_r == OP_RECT && seg_r != SEG_VR) begin
              seg_r <= seg_r + 3'd1; state_r <= S_SEG;
            end else if (op_r == OP_FILL) begin
              seg_r <= SEG_RCHK; state_r <= S_CHK;
            end else state_r <= S_DONE;
          end else state_r <= S_RD;
        end
        S_RD:   state_r <= S_WAIT;
        S_WAIT: state_r <= S_WR;
        S_WR:   state_r <= S_NEXT;
        S_NEXT: state_r <= (op_r == OP_PIXEL) ? S_DONE : S_CHK;
        S_CLR:  if (sts.clr_last) state_r <= S_DONE;
        S_RDB:  state_r <= S_RDW;
        S_RDW:  state_r <= S_CAP;
        S_CAP:  state_r <= S_DONE;
        S_DONE: begin done_r <= 1'b1; state_r <= S_IDLE; end
        S_BINIT: state_r <= S_BOOT;
        // clearing pass after reset, no result
        S_BOOT: if (sts.clr_last) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mono_framebuffer_line_rect_drawer_unit.sv =====
// Top level of the mono framebuffer drawing engine.
// Depends on mfb_pkg, mfb_ctrl, mfb_datapath, mfb_ram.
`timescale 1ns / 1ps
`default_nettype none
// Drawing engine over a page-organised 1 bpp frame store (one byte holds eight
// vertical pixels). A command is taken when start is high and busy is low; busy
// stays high until out_valid pulses for one cycle with out_read_data (the byte
// for a read, zero otherwise). The receiver cannot stall. Each pixel passes
// check, read, read wait, write and step on the single store port, after a
// set-up per segment or fill row; clear writes zero to each store byte in turn;
// a read addresses the store, waits, then captures the byte for its result.
// After reset the engine clears the store itself and holds busy until done.
module mono_framebuffer_line_rect_drawer_unit
  import mfb_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [7:0]  in_start_x,
  input  wire logic [7:0]  in_start_y,
  input  wire logic [7:0]  in_end_x,
  input  wire logic [7:0]  in_end_y,
  input  wire logic [7:0]  in_span_width,
  input  wire logic [7:0]  in_span_height,
  input  wire logic        in_ink,
  input  wire logic [10:0] in_byte_index,
  output logic             out_valid,
  output logic [7:0]       out_read_data
);
  mfb_cmd_t cmd;
  mfb_sts_t sts;

  mfb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_op(in_op), .sts(sts),
    .cmd(cmd), .busy(busy), .done(out_valid)
  );

  mfb_datapath #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .in_start_x(in_start_x), .in_start_y(in_start_y), .in_end_x(in_end_x),
    .in_end_y(in_end_y), .in_span_width(in_span_width),
    .in_span_height(in_span_height), .in_ink(in_ink),
    .in_byte_index(in_byte_index), .out_read_data(out_read_data)
  );

`ifndef SYNTHESIS
  a_no_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a transaction");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction not busy");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy after result");
`endif
endmodule
`default_nettype wire

// ===== dv/mono_framebuffer_line_rect_drawer_unit_tb.sv =====
// Self-checking testbench for the mono framebuffer drawing engine: drives
// drawing commands and byte reads, predicts every result from a model store.
// Depends on mfb_pkg and mono_framebuffer_line_rect_drawer_unit.
`timescale 1ns / 1ps
module mono_framebuffer_line_rect_drawer_unit_tb;
  import mfb_pkg::*;

  localparam int PW = 128;
  localparam int PH = 128;
  localparam int FB_BYTES = PW * ((PH + PAGE_ROWS - 1) / PAGE_ROWS);

  typedef struct {
    op_t        op;
    logic [7:0] sx, sy, ex, ey, w, h;
    logic       ink;
    logic [10:0] idx;
    bit         drain;  // wait for all results before issuing
  } draw_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_op = '0;
  logic [7:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic [7:0] in_span_width = '0, in_span_height = '0;
  logic in_ink = 1'b0;
  logic [10:0] in_byte_index = '0;
  logic out_valid;
  logic [7:0] out_read_data;

  draw_cmd_t cmd_q[$];
  logic [7:0] exp_byte_q[$];
  draw_cmd_t cur_cmd;
  logic [7:0] fb_mem [FB_BYTES];
  int gap_left = 0;
  bit burst = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_reads = 0;

  always #6 clk = ~clk;

  mono_framebuffer_line_rect_drawer_unit #(.PANEL_WIDTH(PW), .PANEL_HEIGHT(PH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_span_width(in_span_width),
    .in_span_height(in_span_height), .in_ink(in_ink), .in_byte_index(in_byte_index),
    .out_valid(out_valid), .out_read_data(out_read_data)
  );

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // ---- framebuffer prediction ----
  function automatic void fb_plot(input int x, input int y, input logic ink);
    int a;
    x &= 255;
    y &= 255;
    if (x >= PW || y >= PH) return;
    a = x + (y / PAGE_ROWS) * PW;
    if (a >= FB_BYTES) return;
    fb_mem[a][y % PAGE_ROWS] = ink;
  endfunction

  function automatic void fb_hspan(input int x, input int y, input int n, input logic ink);
    for (int i = 0; i < n; i++) fb_plot(x + i, y, ink);
  endfunction

  function automatic void fb_vspan(input int x, input int y, input int n, input logic ink);
    for (int i = 0; i < n; i++) fb_plot(x, y + i, ink);
  endfunction

  function automatic void fb_line(input int x0, input int y0, input int x1, input int y1,
                                  input logic ink);
    int dx, dy, err, e;
    bit xup, yup;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    xup = x0 < x1;
    yup = y0 < y1;
    err = dx - dy;
    for (int g = 0; g < 1024; g++) begin
      fb_plot(x0, y0, ink);
      if (x0 == x1 && y0 == y1) break;
      e = err * 2;
      if (e > -dy) begin
        err -= dy;
        x0 = (xup ? x0 + 1 : x0 + 255) & 255;
      end
      if (e < dx) begin
        err += dx;
        y0 = (yup ? y0 + 1 : y0 + 255) & 255;
      end
    end
  endfunction

  function automatic logic [7:0] fb_apply(input draw_cmd_t c);
    logic [7:0] rd;
    int sx, sy, ex, ey, w, h;
    rd = '0;
    sx = int'(c.sx); sy = int'(c.sy); ex = int'(c.ex); ey = int'(c.ey);
    w = int'(c.w); h = int'(c.h);
    case (c.op)
      OP_PIXEL: fb_plot(sx, sy, c.ink);
      OP_LINE:  fb_line(sx, sy, ex, ey, c.ink);
      OP_HSPAN: fb_hspan(sx, sy, w, c.ink);
      OP_VSPAN: fb_vspan(sx, sy, h, c.ink);
      OP_RECT: begin
        fb_hspan(sx, sy, w, c.ink);
        fb_hspan(sx, (sy + h + 255) & 255, w, c.ink);
        fb_vspan(sx, sy, h, c.ink);
        fb_vspan((sx + w + 255) & 255, sy, h, c.ink);
      end
      OP_FILL: for (int i = 0; i < h; i++) fb_hspan(sx, sy + i, w, c.ink);
      OP_CLEAR: for (int i = 0; i < FB_BYTES; i++) fb_mem[i] = '0;
      default: if (c.idx < FB_BYTES) rd = fb_mem[c.idx];
    endcase
    return rd;
  endfunction

  // ---- stimulus helpers ----
  task automatic add_cmd(input op_t op, input int sx, input int sy, input int ex,
                         input int ey, input int w, input int h, input bit ink,
                         input int idx, input bit drain = 0);
    draw_cmd_t c;
    c.op = op; c.sx = 8'(sx); c.sy = 8'(sy); c.ex = 8'(ex); c.ey = 8'(ey);
    c.w = 8'(w); c.h = 8'(h); c.ink = ink; c.idx = 11'(idx); c.drain = drain;
    cmd_q.push_back(c);
  endtask

  function automatic int rand_coord();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, PW - 1);
  endfunction

  function automatic int rand_len();
    case ($urandom_range(0, 19))
      0: return $urandom_range(0, 255);
      1: return 0;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  task automatic add_random_cmd();
    draw_cmd_t c;
    int sel, x, y;
    sel = $urandom_range(0, 99);
    x = rand_coord();
    y = rand_coord();
    c.sx = 8'(x); c.sy = 8'(y);
    c.ex = 8'($urandom); c.ey = 8'($urandom); c.w = 8'($urandom); c.h = 8'($urandom);
    c.ink = ($urandom_range(0, 3) != 0);
    c.idx = 11'($urandom);
    c.drain = ($urandom_range(0, 49) == 0);
    if (sel < 35) c.op = OP_READ;
    else if (sel < 45) c.op = OP_PIXEL;
    else if (sel < 60) begin
      c.op = OP_LINE;
      if ($urandom_range(0, 4) != 0) begin
        // short local line
        c.ex = 8'(x + $urandom_range(0, 40) - 20);
        c.ey = 8'(y + $urandom_range(0, 40) - 20);
      end
    end
    else if (sel < 70) c.op = OP_HSPAN;
    else if (sel < 80) c.op = OP_VSPAN;
    else if (sel < 88) c.op = OP_RECT;
    else if (sel < 97) c.op = OP_FILL;
    else c.op = OP_CLEAR;
    if (c.op inside {OP_HSPAN, OP_VSPAN, OP_RECT}) begin
      c.w = 8'(rand_len()); c.h = 8'(rand_len());
    end
    if (c.op == OP_FILL) begin
      // keep fills modest; a full-size fill runs in the directed part
      c.w = 8'($urandom_range(0, 20)); c.h = 8'($urandom_range(0, 20));
    end
    cmd_q.push_back(c);
  endtask

  // ---- driver ----
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        exp_byte_q.push_back(fb_apply(cur_cmd));
        if (cur_cmd.op == OP_READ) n_reads++;
        gap_left = burst ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 39) == 0) burst = !burst;
      end
      if (start && busy) begin
        // transaction still pending; hold
      end else if (cmd_q.size() != 0 && gap_left == 0 &&
                   !(cmd_q[0].drain && exp_byte_q.size() != 0)) begin
        cur_cmd = cmd_q.pop_front();
        start <= 1'b1;
        in_op <= cur_cmd.op;
        in_start_x <= cur_cmd.sx;
        in_start_y <= cur_cmd.sy;
        in_end_x <= cur_cmd.ex;
        in_end_y <= cur_cmd.ey;
        in_span_width <= cur_cmd.w;
        in_span_height <= cur_cmd.h;
        in_ink <= cur_cmd.ink;
        in_byte_index <= cur_cmd.idx;
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (exp_byte_q.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with no command outstanding",
                                  out_read_data));
      end else begin
        logic [7:0] want;
        want = exp_byte_q.pop_front();
        n_checked++;
        if (out_read_data !== want)
          report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h",
                                    out_read_data, want));
      end
    end
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < FB_BYTES; i++) fb_mem[i] = '0;
    // blank store after reset; clear it again and read it back
    add_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 0, 1, 0);
    add_cmd(OP_PIXEL, 127, 127, 0, 0, 0, 0, 1, 0);
    add_cmd(OP_PIXEL, 128, 5, 0, 0, 0, 0, 1, 0);     // clipped
    add_cmd(OP_PIXEL, 255, 255, 255, 255, 255, 255, 1, 2047);
    add_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 2047);
    add_cmd(OP_LINE, 0, 0, 255, 255, 0, 0, 1, 0);
    add_cmd(OP_LINE, 120, 3, 2, 100, 0, 0, 1, 0);
    add_cmd(OP_HSPAN, 250, 9, 0, 0, 20, 0, 1, 0);    // wraps to left edge
    add_cmd(OP_HSPAN, 10, 10, 0, 0, 0, 0, 1, 0);
    add_cmd(OP_VSPAN, 7, 250, 0, 0, 0, 20, 1, 0);
    add_cmd(OP_VSPAN, 7, 7, 0, 0, 0, 0, 1, 0);
    add_cmd(OP_RECT, 20, 20, 0, 0, 0, 0, 1, 0);      // degenerate outline
    add_cmd(OP_RECT, 30, 40, 0, 0, 0, 9, 1, 0);
    add_cmd(OP_RECT, 0, 0, 0, 0, 255, 255, 1, 0);
    add_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 1);
    add_cmd(OP_FILL, 0, 0, 0, 0, 255, 255, 1, 0);
    add_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1027);
    add_cmd(OP_PIXEL, 5, 13, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 133);
    add_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0);
    add_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1027);
    repeat (700) add_random_cmd();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (cmd_q.size() == 0 && !start && exp_byte_q.size() == 0);
    repeat (50) @(posedge clk);
    $display("Checked %0d results (%0d byte reads) over pixels, lines, spans,",
             n_checked, n_reads);
    $display("outlines, fills and clears with random sender gaps.");
    if (n_errors == 0 && exp_byte_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
